/* hw/rtl/vgroove_shadow_factor_unit_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the v-groove shadow factor unit
// Each macro gives a named concurrent assertion, or nothing in synthesis.
// ---------------------------------------------------------------------------
`ifndef VGROOVE_SHADOW_FACTOR_UNIT_DEFINES_SVH
`define VGROOVE_SHADOW_FACTOR_UNIT_DEFINES_SVH
`ifndef SYNTH
`define VSF_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define VSF_ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`else
`define VSF_ASSERT(label, clk, rstn, prop, msg)
`define VSF_ASSERT_NEXT(label, clk, rstn, pre, post, msg)
`endif
`endif

/* hw/rtl/vsf_pkg.sv */
// ---------------------------------------------------------------------------
// V-groove shadow factor package
// Widths, CORDIC constants and shared helpers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package vsf_pkg;
  localparam int unsigned ANGLE_BITS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned FIELD_BITS     = 16;
  localparam int unsigned CORDIC_ITERS   = 30;
  // Q30 values carry sign and three integer bits beyond the fraction.
  localparam int unsigned QW             = 34;
  localparam logic signed [QW-1:0] CORDIC_GAIN = 34'sh026DD3B6A;
  localparam logic signed [QW-1:0] Q30_ONE     = 34'sh040000000;

  function automatic logic [31:0] atan_phase(input int unsigned i);
    logic [31:0] t [CORDIC_ITERS];
    t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
          32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
          32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
          32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
          32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
          32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001};
    return t[i];
  endfunction

  typedef struct packed {
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [33:0]   z;
    logic                 flip;
  } cordic_t;
endpackage

/* hw/rtl/vsf_cordic.sv */
// ---------------------------------------------------------------------------
// V-groove shadow factor CORDIC
// Pipelined rotation CORDIC, one iteration per stage, giving cosine and sine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module vsf_cordic #(
  parameter int unsigned AngleBits = vsf_pkg::ANGLE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [vsf_pkg::FIELD_BITS-1:0]  angle_i,
  output logic signed [vsf_pkg::QW-1:0]   cos_o,
  output logic signed [vsf_pkg::QW-1:0]   sin_o
);
  localparam int unsigned N = vsf_pkg::CORDIC_ITERS;
  localparam int unsigned QW = vsf_pkg::QW;

  logic [63:0] ext;
  logic [31:0] ph, phf;
  logic        flip;
  vsf_pkg::cordic_t st_q [N+1];
  vsf_pkg::cordic_t st_d [N+1];

  always_comb begin
    ext  = {{(64-vsf_pkg::FIELD_BITS){angle_i[vsf_pkg::FIELD_BITS-1]}}, angle_i};
    ph   = ext[31:0] << (32 - AngleBits);
    flip = ph[31] ^ ph[30];
    phf  = flip ? (ph - 32'h80000000) : ph;
    st_d[0].x    = vsf_pkg::CORDIC_GAIN;
    st_d[0].y    = '0;
    st_d[0].z    = {{2{phf[31]}}, phf};
    st_d[0].flip = flip;
    for (int i = 0; i < N; i++) begin
      st_d[i+1].flip = st_q[i].flip;
      if (!st_q[i].z[33]) begin
        st_d[i+1].x = st_q[i].x - (st_q[i].y >>> i);
        st_d[i+1].y = st_q[i].y + (st_q[i].x >>> i);
        st_d[i+1].z = st_q[i].z - $signed({2'b00, vsf_pkg::atan_phase(i)});
      end else begin
        st_d[i+1].x = st_q[i].x + (st_q[i].y >>> i);
        st_d[i+1].y = st_q[i].y - (st_q[i].x >>> i);
        st_d[i+1].z = st_q[i].z + $signed({2'b00, vsf_pkg::atan_phase(i)});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i <= N; i++) st_q[i] <= st_d[i];
    end
  end

  logic signed [QW-1:0] xo, yo;
  always_comb begin
    xo = st_q[N].flip ? -st_q[N].x : st_q[N].x;
    yo = st_q[N].flip ? -st_q[N].y : st_q[N].y;
    cos_o = (xo > vsf_pkg::Q30_ONE) ? vsf_pkg::Q30_ONE :
            (xo < -vsf_pkg::Q30_ONE) ? -vsf_pkg::Q30_ONE : xo;
    sin_o = (yo > vsf_pkg::Q30_ONE) ? vsf_pkg::Q30_ONE :
            (yo < -vsf_pkg::Q30_ONE) ? -vsf_pkg::Q30_ONE : yo;
  end
endmodule

/* hw/rtl/vsf_divider.sv */
// ---------------------------------------------------------------------------
// V-groove shadow factor ratio divider
// Pipelined restoring division, one quotient bit per stage, with bounding.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module vsf_divider #(
  parameter int unsigned FracBits = vsf_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [63:0]    num_i,
  input  logic signed [63:0]    den_i,
  output logic signed [FracBits+1:0] ratio_o
);
  localparam int unsigned S = FracBits + 2;
  typedef struct packed {
    logic [63:0]          r;
    logic [63:0]          d;
    logic [FracBits+1:0]  q;
    logic                 neg;
    logic                 hi;
    logic                 lo;
  } div_t;
  div_t s_q [S];
  div_t s_d [S];
  logic [63:0] a;

  always_comb begin
    a = num_i[63] ? 64'(-num_i) : 64'(num_i);
    s_d[0].d   = den_i;
    s_d[0].neg = num_i[63];
    s_d[0].hi  = num_i >= den_i;
    s_d[0].lo  = num_i <= -(den_i <<< 1);
    s_d[0].q   = '0;
    if (a >= den_i) begin
      s_d[0].r = a - den_i;
      s_d[0].q[0] = 1'b1;
    end else begin
      s_d[0].r = a;
    end
    for (int j = 1; j < S; j++) begin
      s_d[j] = s_q[j-1];
      s_d[j].q = {s_q[j-1].q[FracBits:0], 1'b0};
      s_d[j].r = s_q[j-1].r << 1;
      if ((s_q[j-1].r << 1) >= s_q[j-1].d) begin
        s_d[j].q[0] = 1'b1;
        s_d[j].r = (s_q[j-1].r << 1) - s_q[j-1].d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < S; j++) s_q[j] <= s_d[j];
    end
  end

  // The rounding add needs one extra bit when the quotient is all ones.
  logic [FracBits+1:0] qr;
  always_comb begin
    qr = (FracBits+2)'(({1'b0, s_q[S-1].q} + (FracBits+3)'(1)) >> 1);
    if (s_q[S-1].hi) ratio_o = (FracBits+2)'(1) << FracBits;
    else if (s_q[S-1].lo) ratio_o = -((FracBits+2)'(1) << (FracBits + 1));
    else ratio_o = s_q[S-1].neg ? -$signed(qr) : $signed(qr);
  end
endmodule

/* hw/rtl/vgroove_shadow_factor_unit.sv */
// ---------------------------------------------------------------------------
// V-groove shadow factor unit
// Cook-Torrance geometric attenuation from three binary angles.
// ---------------------------------------------------------------------------
// One item enters per cycle while the output is not stalled. Its result passes
// through 31 CORDIC register stages, two multiply stages, one denominator stage,
// FRAC_BITS+2 restoring divider stages and the output register, the first
// loaded at the accepting edge. Backpressure stalls the whole
// pipeline; the output register holds the waiting result.
`timescale 1ns / 1ps
`include "vgroove_shadow_factor_unit_defines.svh"
module vgroove_shadow_factor_unit #(
  parameter int unsigned ANGLE_BITS = vsf_pkg::ANGLE_BITS_DEF,
  parameter int unsigned FRAC_BITS  = vsf_pkg::FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // incidence_angle[15:0], scatter_angle[31:16], azimuth_angle[47:32]
  input  logic [47:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // shadow_factor[FRAC_BITS+1:0], zero fill above
  output logic [((FRAC_BITS+2+7)/8)*8-1:0] m_axis_tdata_o,
  // degenerate
  output logic        m_axis_tuser_o
);
  localparam int unsigned QW   = vsf_pkg::QW;
  localparam int unsigned OW   = FRAC_BITS + 2;
  localparam int unsigned LAT  = vsf_pkg::CORDIC_ITERS + 1 + 3 + FRAC_BITS + 2 + 1;

  logic en;
  logic [LAT-1:0] vld_q;
  assign en = !vld_q[LAT-1] || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid_i};
    end
  end

  logic signed [QW-1:0] ci, si, cs, ss, cp, sp;
  vsf_cordic #(.AngleBits(ANGLE_BITS)) u_ci (.clk_i, .en_i(en),
    .angle_i(s_axis_tdata_i[15:0]), .cos_o(ci), .sin_o(si));
  vsf_cordic #(.AngleBits(ANGLE_BITS)) u_cs (.clk_i, .en_i(en),
    .angle_i(s_axis_tdata_i[31:16]), .cos_o(cs), .sin_o(ss));
  vsf_cordic #(.AngleBits(ANGLE_BITS)) u_cp (.clk_i, .en_i(en),
    .angle_i(s_axis_tdata_i[47:32]), .cos_o(cp), .sin_o(sp));

  // Stage A: first products.
  logic signed [63:0] ss_prod_q, cc_q, sum_q;
  logic signed [QW-1:0] ci_a_q, cs_a_q, cp_a_q;
  // Stage B: rounded sine product times cos_phi, numerators.
  logic signed [63:0] tc_q, cc_b_q, ni_q, ns_q;
  // Stage C: denominator.
  logic signed [63:0] den_q, ni_c_q, ns_c_q;
  logic signed [63:0] t;
  always_comb t = (ss_prod_q + 64'sd536870912) >>> 30;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ss_prod_q <= 64'(si) * 64'(ss) + 64'sd0 * sp[0];
      cc_q      <= 64'(ci) * 64'(cs);
      sum_q     <= 64'(ci) + 64'(cs);
      ci_a_q <= ci; cs_a_q <= cs; cp_a_q <= cp;
      tc_q   <= t * 64'(cp_a_q);
      cc_b_q <= cc_q;
      ni_q   <= (sum_q <<< 1) * 64'(ci_a_q);
      ns_q   <= (sum_q <<< 1) * 64'(cs_a_q);
      den_q  <= (64'sd1 <<< 60) + cc_b_q - tc_q;
      ni_c_q <= ni_q; ns_c_q <= ns_q;
    end
  end

  logic signed [63:0] dsafe;
  assign dsafe = (den_q <= 0) ? 64'sd1 : den_q;
  logic [FRAC_BITS+1:0] degen_q;
  always_ff @(posedge clk_i) begin
    if (en) degen_q <= {degen_q[FRAC_BITS:0], den_q <= 0};
  end

  logic signed [OW-1:0] gi, gs, g;
  vsf_divider #(.FracBits(FRAC_BITS)) u_div_i (.clk_i, .en_i(en),
    .num_i(ni_c_q), .den_i(dsafe), .ratio_o(gi));
  vsf_divider #(.FracBits(FRAC_BITS)) u_div_s (.clk_i, .en_i(en),
    .num_i(ns_c_q), .den_i(dsafe), .ratio_o(gs));

  localparam logic signed [OW-1:0] ONE = OW'(1) << FRAC_BITS;
  always_comb begin
    g = ONE;
    if (gi < g) g = gi;
    if (gs < g) g = gs;
    if (degen_q[FRAC_BITS+1]) g = ONE;
  end

  logic [OW-1:0] out_q;
  logic          deg_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= g;
      deg_q <= degen_q[FRAC_BITS+1];
    end
  end
  assign m_axis_tdata_o = $bits(m_axis_tdata_o)'(out_q);
  assign m_axis_tuser_o = deg_q;

  `VSF_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(out_q), "stalled result changed")
  `VSF_ASSERT(a_ready_when_free, clk_i, rst_ni, !m_axis_tvalid_o |-> s_axis_tready_o, "input blocked with empty output")
  `VSF_ASSERT(a_degenerate_one, clk_i, rst_ni, (m_axis_tvalid_o && deg_q) |-> (out_q == ONE), "degenerate result is not one")
endmodule
